// ----- hw/rtl/polynomial_riemann_integrator_macros.svh -----
// ----------------------------------------------------------------------------
// Polynomial Riemann integrator assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_RIEMANN_INTEGRATOR_MACROS_SVH
`define POLYNOMIAL_RIEMANN_INTEGRATOR_MACROS_SVH

// Same-cycle implication: when pre holds, post holds too
`define PRI_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pri: same-cycle check failed");

// Next-cycle implication: when pre holds, post holds in the next cycle
`define PRI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pri: next-cycle check failed");

`endif

// ----- hw/rtl/pri_pkg.sv -----
// ----------------------------------------------------------------------------
// pri_pkg
// Types and constants shared by the polynomial Riemann integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pri_pkg;

  // Coefficient store geometry
  localparam int unsigned MAX_COEFS = 1024;
  localparam int unsigned COEF_AW   = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int unsigned COUNT_W   = $clog2(MAX_COEFS + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BOUND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDTH  = 2'd2;

  // Configuration reset values
  localparam logic [31:0] LEFT_BOUND_RST  = 32'sd0;
  localparam logic [31:0] RIGHT_BOUND_RST = 32'sd65536;
  localparam logic [30:0] STEP_WIDTH_RST  = 31'd66;

  // Saturation limits
  localparam logic [31:0] Q32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q32_MIN = 32'h8000_0000;
  localparam logic [63:0] Q64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q64_MIN = 64'h8000_0000_0000_0000;

  // Input request payload
  typedef struct packed {
    logic signed [31:0] coef_value;
    logic               coef_last;
  } pri_in_t;

  // Result payload
  typedef struct packed {
    logic signed [63:0] integral_value;
    logic               overflow;
    logic               too_many;
  } pri_out_t;

  // Integration job handed from the loader to the engine
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        step;
    logic [COUNT_W-1:0] count;
    logic               too_many;
  } pri_job_t;

  // Coefficient store read request
  typedef struct packed {
    logic               re;
    logic [COEF_AW-1:0] addr;
  } pri_rd_req_t;

endpackage

// ----- hw/rtl/pri_ram.sv -----
// ----------------------------------------------------------------------------
// pri_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pri_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pri_engine.sv -----
// ----------------------------------------------------------------------------
// pri_engine
// Riemann sum sequencer: Horner evaluation from the coefficient store,
// term multiply and saturating Q47.16 accumulation on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pri_engine import pri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  pri_job_t    job_i,
  input  logic        ack_i,
  output logic        busy_o,
  output logic        done_o,
  output pri_out_t    result_o,
  output pri_rd_req_t rd_req_o,
  input  logic [31:0] rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_HORNER,
    S_TERM,
    S_ACCUM,
    S_FINISH,
    S_DONE
  } state_e;

  state_e             state_q;
  logic signed [33:0] walk_q;
  logic signed [31:0] hi_q;
  logic [30:0]        step_q;
  logic [COUNT_W-1:0] n_q;
  logic [COUNT_W-1:0] idx_q;
  logic signed [31:0] y_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic               ovf_q;
  logic               neg_q;
  logic               many_q;
  pri_out_t           res_q;

  // Start decode: order the bounds, force a nonzero step
  logic               swap;
  logic signed [31:0] lo_s;
  logic signed [31:0] hi_s;
  logic [30:0]        step_eff;
  always_comb begin
    swap     = job_i.hi < job_i.lo;
    lo_s     = swap ? job_i.hi : job_i.lo;
    hi_s     = swap ? job_i.lo : job_i.hi;
    step_eff = (job_i.step == 31'd0) ? 31'd1 : job_i.step;
  end

  // Shared multiplier: y * x while evaluating, y * step for the term
  logic signed [31:0] mul_b;
  logic signed [63:0] product;
  always_comb begin
    mul_b   = (state_q == S_TERM) ? $signed({1'b0, step_q}) : walk_q[31:0];
    product = y_q * mul_b;
  end

  // Horner update: asr16(y * x) + coef * 2^16, saturated to 32 bits
  logic signed [48:0] h_shift;
  logic signed [48:0] h_coef;
  logic signed [48:0] h_sum;
  logic               h_pos_ovf;
  logic               h_neg_ovf;
  logic signed [31:0] y_next;
  always_comb begin
    h_shift   = {prod_q[63], prod_q[63:16]};
    h_coef    = {rd_data_i[31], rd_data_i, 16'd0};
    h_sum     = h_shift + h_coef;
    h_pos_ovf = !h_sum[48] && (|h_sum[47:31]);
    h_neg_ovf = h_sum[48] && !(&h_sum[47:31]);
    if (h_pos_ovf) begin
      y_next = Q32_MAX;
    end else if (h_neg_ovf) begin
      y_next = Q32_MIN;
    end else begin
      y_next = h_sum[31:0];
    end
  end

  // Accumulate: acc + asr16(y * step), saturated to 64 bits
  logic signed [63:0] term;
  logic signed [64:0] a_sum;
  logic               a_ovf;
  logic signed [63:0] acc_next;
  always_comb begin
    term     = {{16{prod_q[63]}}, prod_q[63:16]};
    a_sum    = {acc_q[63], acc_q} + {term[63], term};
    a_ovf    = a_sum[64] != a_sum[63];
    acc_next = a_ovf ? (a_sum[64] ? Q64_MIN : Q64_MAX) : a_sum[63:0];
  end

  // Advance the sample point
  logic signed [33:0] walk_next;
  logic               more;
  logic [COUNT_W-1:0] idx_inc;
  always_comb begin
    walk_next = walk_q + $signed({3'b000, step_q});
    more      = walk_next < $signed({{2{hi_q[31]}}, hi_q});
    idx_inc   = idx_q + COUNT_W'(1);
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= '0;
      hi_q    <= '0;
      step_q  <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      y_q     <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      neg_q   <= 1'b0;
      many_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            walk_q <= {{2{lo_s[31]}}, lo_s};
            hi_q   <= hi_s;
            step_q <= step_eff;
            n_q    <= job_i.count;
            idx_q  <= '0;
            y_q    <= '0;
            acc_q  <= '0;
            ovf_q  <= 1'b0;
            neg_q  <= swap;
            many_q <= job_i.too_many;
            state_q <= (lo_s < hi_s) ? S_READ : S_FINISH;
          end
        end
        S_READ: begin
          prod_q  <= product;
          state_q <= S_HORNER;
        end
        S_HORNER: begin
          y_q   <= y_next;
          ovf_q <= ovf_q | h_pos_ovf | h_neg_ovf;
          idx_q <= idx_inc;
          state_q <= (idx_inc == n_q) ? S_TERM : S_READ;
        end
        S_TERM: begin
          prod_q  <= product;
          state_q <= S_ACCUM;
        end
        S_ACCUM: begin
          acc_q  <= acc_next;
          ovf_q  <= ovf_q | a_ovf;
          walk_q <= walk_next;
          y_q    <= '0;
          idx_q  <= '0;
          state_q <= more ? S_READ : S_FINISH;
        end
        S_FINISH: begin
          // Negate for swapped bounds; the minimum saturates to the maximum
          if (neg_q && (acc_q == Q64_MIN)) begin
            res_q.integral_value <= Q64_MAX;
            res_q.overflow       <= 1'b1;
          end else begin
            res_q.integral_value <= neg_q ? -acc_q : acc_q;
            res_q.overflow       <= ovf_q;
          end
          res_q.too_many <= many_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = state_q != S_IDLE;
  assign done_o        = state_q == S_DONE;
  assign result_o      = res_q;
  assign rd_req_o.re   = state_q == S_READ;
  assign rd_req_o.addr = idx_q[COEF_AW-1:0];

endmodule

// ----- hw/rtl/polynomial_riemann_integrator.sv -----
// ----------------------------------------------------------------------------
// polynomial_riemann_integrator
// Left Riemann sum of an integer-coefficient polynomial in Q16.16 / Q47.16.
// ----------------------------------------------------------------------------
// Coefficient requests are taken one per cycle, highest power first, into a
// 1024-entry coefficient RAM; the request marked last starts the integration
// and the input stalls until the engine is free again. With n stored
// coefficients and S sample points, S = ceil((hi - lo) / step), each sample
// takes n Horner steps: each Horner step needs one RAM read plus one pass
// through the single 32x32 multiplier, and each sample adds one term
// multiply and one accumulate. Equal bounds give a zero result. A finished
// result waits in the output register while new coefficients are loaded.
`timescale 1ns / 1ps
`include "polynomial_riemann_integrator_macros.svh"

module polynomial_riemann_integrator import pri_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Coefficient requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pri_in_t              in_data_i,
  // Results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pri_out_t             out_data_o,
  // Configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic signed [31:0] left_bound_q;
  logic signed [31:0] right_bound_q;
  logic [30:0]        step_width_q;
  logic [COUNT_W-1:0] coef_count_q;
  logic               dropped_q;
  logic               out_valid_q;
  pri_out_t           out_data_q;

  logic               eng_busy;
  logic               eng_done;
  logic               eng_ack;
  pri_out_t           eng_result;
  pri_rd_req_t        rd_req;
  logic [31:0]        rd_data;
  pri_job_t           job;

  // Request handshake
  logic in_accept;
  logic room;
  logic last_accept;
  assign in_stall_o  = eng_busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign room        = coef_count_q < COUNT_W'(MAX_COEFS);
  assign last_accept = in_accept && in_data_i.coef_last;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bound_q  <= LEFT_BOUND_RST;
      right_bound_q <= RIGHT_BOUND_RST;
      step_width_q  <= STEP_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEFT_BOUND:  left_bound_q  <= cfg_data_i;
        CFG_RIGHT_BOUND: right_bound_q <= cfg_data_i;
        CFG_STEP_WIDTH:  step_width_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Count stored coefficients; flag drops; clear both when a job starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_count_q <= '0;
      dropped_q    <= 1'b0;
    end else if (last_accept) begin
      coef_count_q <= '0;
      dropped_q    <= 1'b0;
    end else if (in_accept) begin
      if (room) begin
        coef_count_q <= coef_count_q + COUNT_W'(1);
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // Job handed to the engine with the last request
  always_comb begin
    job.lo       = left_bound_q;
    job.hi       = right_bound_q;
    job.step     = step_width_q;
    job.count    = room ? (coef_count_q + COUNT_W'(1)) : coef_count_q;
    job.too_many = dropped_q || !room;
  end

  pri_ram #(
    .WIDTH(32),
    .DEPTH(MAX_COEFS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && room),
    .waddr_i (coef_count_q[COEF_AW-1:0]),
    .wdata_i (in_data_i.coef_value),
    .re_i    (rd_req.re),
    .raddr_i (rd_req.addr),
    .rdata_o (rd_data)
  );

  pri_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (last_accept),
    .job_i     (job),
    .ack_i     (eng_ack),
    .busy_o    (eng_busy),
    .done_o    (eng_done),
    .result_o  (eng_result),
    .rd_req_o  (rd_req),
    .rd_data_i (rd_data)
  );

  // Output register: take the engine result once the slot is free
  assign eng_ack = eng_done && (!out_valid_q || !out_stall_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (eng_ack) begin
      out_valid_q <= 1'b1;
      out_data_q  <= eng_result;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `PRI_ASSERT_IMPL(a_count_in_range, 1'b1, coef_count_q <= COUNT_W'(MAX_COEFS))
  `PRI_ASSERT_NEXT(a_last_starts_job, last_accept, eng_busy && (coef_count_q == '0))
  `PRI_ASSERT_NEXT(a_ack_fills_output, eng_ack, out_valid_q && !eng_done)

endmodule

// ----- test/polynomial_riemann_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// Polynomial Riemann integrator testbench
// Loads polynomials one coefficient request at a time and checks each
// integral, overflow and too_many flag against a cycle-free model of the
// left Riemann sum. A directed table covers reset values, bound and step
// extremes, equal and swapped bounds, zero step, an unused register index
// and a full coefficient store. Random polynomials and register settings
// follow, under three idle and stall profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pri_pkg::*;

  localparam int  WATCHDOG_LIMIT = 60000;
  localparam int  SETTLE_CYCLES  = 8;
  localparam int  END_CYCLES     = 32;
  localparam int  RAND_ITEMS     = 650;
  localparam int  MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint SAT32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT32_LO = -SAT32_HI - 1;

  typedef enum logic {ROW_REG, ROW_COEF} row_kind_e;
  typedef enum int {COEF_SMALL, COEF_WIDE, COEF_MIXED} coef_mix_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
    logic                 last;
    int                   reps;
    bit                   typed;
    pri_out_t             want;
  } probe_row_t;

  // DUT connections
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pri_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  pri_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  // Model state: registers, coefficient store, drop flag
  logic signed [31:0] lo_reg   = LEFT_BOUND_RST;
  logic signed [31:0] hi_reg   = RIGHT_BOUND_RST;
  logic [30:0]        step_reg = STEP_WIDTH_RST;
  logic signed [31:0] coef_mem [0:MAX_COEFS-1];
  int                 coef_cnt  = 0;
  bit                 drop_flag = 1'b0;

  pri_out_t   pending_integrals[$];
  pri_out_t   head_integral;
  probe_row_t plan[$];
  int         bad_results  = 0;
  int         quiet_cycles = 0;
  int         src_idle     = 24;
  int         snk_idle     = 87;

  polynomial_riemann_integrator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Evaluate the stored polynomial at x by Horner's rule, saturating to Q16.16
  function automatic longint poly_at(input longint x, inout bit ovf);
    longint y;
    longint v;
    y = 0;
    for (int i = 0; i < coef_cnt; i++) begin
      v = ((y * x) >>> 16) + longint'(coef_mem[i]) * 64'sd65536;
      if (v > SAT32_HI) begin
        v = SAT32_HI;
        ovf = 1'b1;
      end else if (v < SAT32_LO) begin
        v = SAT32_LO;
        ovf = 1'b1;
      end
      y = v;
    end
    return y;
  endfunction

  // Left Riemann sum over the current bounds, Q47.16 with saturation
  function automatic pri_out_t riemann_sum();
    pri_out_t res;
    longint   lo;
    longint   hi;
    longint   stp;
    longint   x;
    longint   term;
    longint   acc;
    longint   sum;
    bit       ovf;
    bit       flip;
    lo   = lo_reg;
    hi   = hi_reg;
    flip = 1'b0;
    ovf  = 1'b0;
    acc  = 0;
    if (hi < lo) begin
      x    = lo;
      lo   = hi;
      hi   = x;
      flip = 1'b1;
    end
    stp = (step_reg == '0) ? 64'sd1 : longint'(step_reg);
    for (x = lo; x < hi; x += stp) begin
      term = (poly_at(x, ovf) * stp) >>> 16;
      sum  = acc + term;
      if (acc[63] == term[63] && sum[63] != acc[63]) begin
        sum = acc[63] ? Q64_MIN : Q64_MAX;
        ovf = 1'b1;
      end
      acc = sum;
    end
    if (flip) begin
      if (acc == Q64_MIN) begin
        acc = Q64_MAX;
        ovf = 1'b1;
      end else begin
        acc = -acc;
      end
    end
    res.integral_value = acc;
    res.overflow       = ovf;
    res.too_many       = drop_flag;
    return res;
  endfunction

  // Store one accepted coefficient; on the last one, produce the integral
  function automatic void note_coef(input pri_in_t req, output bit done, output pri_out_t res);
    done = 1'b0;
    res  = '0;
    if (coef_cnt < MAX_COEFS) begin
      coef_mem[coef_cnt] = req.coef_value;
      coef_cnt++;
    end else begin
      drop_flag = 1'b1;
    end
    if (req.coef_last) begin
      res       = riemann_sum();
      done      = 1'b1;
      coef_cnt  = 0;
      drop_flag = 1'b0;
    end
  endfunction

  function automatic probe_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    probe_row_t r;
    r       = '{kind: ROW_REG, default: '0};
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  function automatic probe_row_t coef_row(input logic [31:0] val, input logic last, input int reps);
    probe_row_t r;
    r      = '{kind: ROW_COEF, default: '0};
    r.val  = val;
    r.last = last;
    r.reps = reps;
    return r;
  endfunction

  function automatic probe_row_t known_row(input logic [31:0] val, input longint value,
                                           input logic ovf, input logic tm);
    probe_row_t r;
    r       = coef_row(val, 1'b1, 1);
    r.typed = 1'b1;
    r.want.integral_value = value;
    r.want.overflow       = ovf;
    r.want.too_many       = tm;
    return r;
  endfunction

  function automatic logic [31:0] pick_coef(input coef_mix_e mix);
    logic [31:0] c;
    int          roll;
    roll = (mix == COEF_MIXED) ? $urandom_range(2) : int'(mix);
    case (roll)
      0: c = int'($urandom_range(32)) - 16;
      1: c = $urandom;
      default: begin
        case ($urandom_range(4))
          0: c = 32'h7FFF_FFFF;
          1: c = 32'h8000_0000;
          2: c = 32'h0000_0000;
          3: c = 32'hFFFF_FFFF;
          default: c = 32'h0000_0001;
        endcase
      end
    endcase
    return c;
  endfunction

  // Send one coefficient request and queue the integral it completes
  task automatic send_coef(input logic [31:0] coef, input logic last, input bit typed,
                           input pri_out_t known);
    pri_in_t  req;
    pri_out_t res;
    bit       done;
    req.coef_value = coef;
    req.coef_last  = last;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    note_coef(req, done, res);
    if (done) pending_integrals.push_back(typed ? known : res);
  endtask

  // Drop valid, drain all pending integrals, then let the engine go quiet
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_integrals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LEFT_BOUND:  lo_reg   = val;
      CFG_RIGHT_BOUND: hi_reg   = val;
      CFG_STEP_WIDTH:  step_reg = val[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a step, then bounds a dozen steps apart at most, anywhere in range
  task automatic randomize_regs();
    logic [30:0] stp;
    longint      eff;
    longint      span;
    longint      room;
    longint      lo;
    longint      hi;
    int          n;
    case ($urandom_range(7))
      0, 1:    stp = 31'($urandom_range(64, 1));
      2, 3:    stp = 31'($urandom_range(32'h0001_0000, 1));
      4, 5, 6: stp = 31'($urandom);
      default: stp = '0;
    endcase
    eff  = (stp == '0) ? 64'sd1 : longint'(stp);
    n    = $urandom_range(12);
    span = eff * n;
    if (n > 0) span -= $urandom_range(32'(eff - 1));
    if (span > 64'sh0000_0000_FFFF_FFFF) span = 64'sh0000_0000_FFFF_FFFF;
    room = 64'sh0000_0000_FFFF_FFFF - span;
    lo   = longint'({$urandom, $urandom} % (room + 1)) - 64'sh0000_0000_8000_0000;
    hi   = lo + span;
    if ($urandom_range(1)) begin
      write_reg(CFG_LEFT_BOUND, hi[31:0]);
      write_reg(CFG_RIGHT_BOUND, lo[31:0]);
    end else begin
      write_reg(CFG_LEFT_BOUND, lo[31:0]);
      write_reg(CFG_RIGHT_BOUND, hi[31:0]);
    end
    write_reg(CFG_STEP_WIDTH, {1'($urandom_range(1)), stp});
    if ($urandom_range(5) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  // Randomly stall the result side
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_idle);
  end

  // Compare each accepted result with the oldest pending integral
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_integrals.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("mismatch: result with none pending, got %0d ovf %0b too_many %0b",
                   out_data_o.integral_value, out_data_o.overflow, out_data_o.too_many);
      end else begin
        head_integral = pending_integrals.pop_front();
        if (out_data_o.integral_value !== head_integral.integral_value ||
            out_data_o.overflow !== head_integral.overflow ||
            out_data_o.too_many !== head_integral.too_many) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: want %0d ovf %0b too_many %0b, got %0d ovf %0b too_many %0b",
                     head_integral.integral_value, head_integral.overflow,
                     head_integral.too_many, out_data_o.integral_value,
                     out_data_o.overflow, out_data_o.too_many);
        end
      end
    end
  end

  // End the run if no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int        rand_items;
    int        ncoef;
    coef_mix_e mix;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rand_items  = 0;

    // Reset values first, then bound and step corner cases, then a full store
    plan.push_back(known_row(32'd0, 0, 1'b0, 1'b0));
    plan.push_back(known_row(32'd1, 65538, 1'b0, 1'b0));  // 993 samples of 66
    plan.push_back(coef_row(32'd3, 1'b0, 1));
    plan.push_back(coef_row(32'hFFFF_FFFE, 1'b0, 1));
    plan.push_back(coef_row(32'd5, 1'b1, 1));
    plan.push_back(reg_row(CFG_LEFT_BOUND, 32'h0005_0000));
    plan.push_back(reg_row(CFG_RIGHT_BOUND, 32'h0005_0000));
    plan.push_back(known_row(32'd7, 0, 1'b0, 1'b0));
    plan.push_back(reg_row(CFG_LEFT_BOUND, 32'h8000_0000));
    plan.push_back(reg_row(CFG_RIGHT_BOUND, 32'h7FFF_FFFF));
    plan.push_back(reg_row(CFG_STEP_WIDTH, 32'h7FFF_FFFF));
    plan.push_back(coef_row(32'h7FFF_FFFF, 1'b1, 1));
    plan.push_back(coef_row(32'h8000_0000, 1'b0, 1));
    plan.push_back(coef_row(32'h7FFF_FFFF, 1'b0, 1));
    plan.push_back(coef_row(32'h8000_0000, 1'b1, 1));
    // Zero step acts as one LSB; three samples of a constant one
    plan.push_back(reg_row(CFG_STEP_WIDTH, 32'h8000_0000));
    plan.push_back(reg_row(CFG_LEFT_BOUND, 32'd0));
    plan.push_back(reg_row(CFG_RIGHT_BOUND, 32'd3));
    plan.push_back(known_row(32'd1, 3, 1'b0, 1'b0));
    // Swapped bounds negate
    plan.push_back(reg_row(CFG_LEFT_BOUND, 32'd3));
    plan.push_back(reg_row(CFG_RIGHT_BOUND, 32'd0));
    plan.push_back(known_row(32'd1, -3, 1'b0, 1'b0));
    plan.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
    plan.push_back(known_row(32'd2, -6, 1'b0, 1'b0));
    // Overfill the store; the dropped last coefficient must not be used
    plan.push_back(reg_row(CFG_LEFT_BOUND, 32'd0));
    plan.push_back(reg_row(CFG_RIGHT_BOUND, 32'd2));
    plan.push_back(coef_row(32'd1, 1'b0, MAX_COEFS + 6));
    plan.push_back(coef_row(32'd9, 1'b1, 1));
    plan.push_back(known_row(32'd1, 2, 1'b0, 1'b0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        settle_block();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        repeat (plan[r].reps) send_coef(plan[r].val, plan[r].last, plan[r].typed, plan[r].want);
      end
    end

    // Random polynomials, mostly short, some long, under changing settings
    while (rand_items < RAND_ITEMS) begin
      if (rand_items >= 2 * RAND_ITEMS / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (rand_items >= RAND_ITEMS / 3) begin
        src_idle = 87;
        snk_idle = 24;
      end
      if ($urandom_range(2) == 0) begin
        settle_block();
        randomize_regs();
      end else if ($urandom_range(7) == 0) begin
        settle_block();
      end
      ncoef = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: mix = COEF_SMALL;
        12, 13, 14, 15, 16:                   mix = COEF_WIDE;
        default:                              mix = COEF_MIXED;
      endcase
      for (int k = 0; k < ncoef; k++) begin
        send_coef(pick_coef(mix), k == ncoef - 1, 1'b0, '0);
        rand_items++;
      end
    end

    settle_block();
    repeat (END_CYCLES) @(posedge clk_i);
    if (bad_results == 0 && pending_integrals.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
